FILE: rtl/lfra_pkg.sv
// Shared constants, codes and types of the lowest-free room allocator.
package lfra_pkg;

	localparam int ROOM_FIELD_W   = 9;
	localparam int GUEST_FIELD_W  = 10;
	localparam int DEF_MAX_GUESTS = 1024;
	localparam int DEF_MAX_ROOMS  = 256;
	localparam int BMP_WORD_W     = 16;
	localparam int BMP_BIT_W      = $clog2(BMP_WORD_W);
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic {
		REQ_ARRIVE = 1'b0,
		REQ_DEPART = 1'b1
	} req_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	typedef struct packed {
		req_kind_t                kind;
		logic                     guest_ok;
		logic [GUEST_FIELD_W-1:0] guest;
	} cmd_t;

endpackage

FILE: rtl/lfra_if.sv
// Request and result channel interfaces of the room allocator.
interface lfra_req_if;
	import lfra_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [GUEST_FIELD_W-1:0] guest;
	modport source (output valid, req_type, guest, input ready);
	modport sink (input valid, req_type, guest, output ready);
endinterface

interface lfra_res_if;
	import lfra_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [ROOM_FIELD_W-1:0] room;
	logic [ROOM_FIELD_W-1:0] occupied;
	logic [ROOM_FIELD_W-1:0] peak;
	logic                    full_res;
	modport source (output valid, room, occupied, peak, full_res, input ready);
	modport sink (input valid, room, occupied, peak, full_res, output ready);
endinterface

FILE: rtl/lowest_free_room_allocator_unit.sv
// Top level of the lowest-free room allocator.
//
//  channel | role | beat fields                          | handshake
//  --------+------+--------------------------------------+-------------
//  req     | in   | req_type, guest                      | valid/ready
//  res     | out  | room, occupied, peak, full_res       | valid/ready
//
// The executor works on one event at a time: first the guest table
// read and bitmap word pick, then the bitmap update and result register.
// Front register and a 2-entry queue let requests come in while it works.
// Reset clears the busy bitmap flops, counters and valids at once; the
// guest table is not cleared. A stalled result beat holds the executor.
module lowest_free_room_allocator_unit #(
	parameter int MAX_GUESTS = lfra_pkg::DEF_MAX_GUESTS,
	parameter int MAX_ROOMS  = lfra_pkg::DEF_MAX_ROOMS
) (
	input  logic       clk,
	input  logic       arst_n,
	lfra_req_if.sink   req,
	lfra_res_if.source res
);
	import lfra_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;

	lfra_front #(
		.MAX_GUESTS(MAX_GUESTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	lfra_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	lfra_back #(
		.MAX_GUESTS(MAX_GUESTS),
		.MAX_ROOMS (MAX_ROOMS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.res      (res)
	);
endmodule

FILE: rtl/lfra_ram.sv
// Generic simple dual-port RAM with registered read.
module lfra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/lfra_front.sv
// Front stage: accept events, check the guest range, hand them to the queue.
module lfra_front #(
	parameter int MAX_GUESTS = lfra_pkg::DEF_MAX_GUESTS
) (
	input  logic          clk,
	input  logic          arst_n,
	lfra_req_if.sink      req,
	output logic          push_valid,
	input  logic          push_ready,
	output lfra_pkg::cmd_t push_data
);
	import lfra_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	logic take;

	assign req.ready = !valid_s1 || push_ready;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// classify: kind and whether the guest lies inside the table
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.kind     <= req_kind_t'(req.req_type);
			cmd_s1.guest_ok <= 32'(req.guest) < 32'(MAX_GUESTS);
			cmd_s1.guest    <= req.guest;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = cmd_s1;
endmodule

FILE: rtl/lfra_queue.sv
// Short command queue between the front and back stages.
module lfra_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  lfra_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output lfra_pkg::cmd_t pop_data
);
	import lfra_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != CW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

FILE: rtl/lfra_back.sv
// Back stage: guest table lookup, busy bitmap pick and update, result register.
module lfra_back #(
	parameter int MAX_GUESTS = lfra_pkg::DEF_MAX_GUESTS,
	parameter int MAX_ROOMS  = lfra_pkg::DEF_MAX_ROOMS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  lfra_pkg::cmd_t pop_data,
	lfra_res_if.source     res
);
	import lfra_pkg::*;

	localparam int RW     = $clog2(MAX_ROOMS + 1);
	localparam int RIW    = $clog2(MAX_ROOMS);
	localparam int GW     = $clog2(MAX_GUESTS);
	localparam int NWORDS = (MAX_ROOMS + BMP_WORD_W - 1) / BMP_WORD_W;
	localparam int NWW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int PADW   = NWORDS * BMP_WORD_W;

	back_state_t state_q, state_d;

	logic [MAX_ROOMS-1:0]  busy_q;
	logic [PADW-1:0]       busy_pad;
	logic [BMP_WORD_W-1:0] words [NWORDS];
	logic [NWORDS-1:0]     word_full;
	logic [NWW-1:0]        free_word;
	logic                  free_any;

	cmd_t                  cmd_q;
	logic [NWW-1:0]        word_sel_q;
	logic                  word_any_q;
	logic [RW-1:0]         occ_q;
	logic [RW-1:0]         peak_q;

	logic [BMP_WORD_W-1:0] word_cur;
	logic [BMP_BIT_W-1:0]  low_bit;
	logic [RW-1:0]         alloc_room;
	logic [RIW-1:0]        alloc_idx;
	logic [RW-1:0]         held;
	logic [RIW-1:0]        held_idx;
	logic                  held_ok;
	logic                  arrive;
	logic                  do_alloc;
	logic                  do_free;
	logic [RW-1:0]         occ_inc;
	logic [RW-1:0]         occ_d;
	logic [RW-1:0]         peak_d;
	logic [RW-1:0]         room_d;
	logic                  full_d;

	logic                  take;
	logic                  commit;
	logic                  out_free;

	logic                  ram_we;
	logic [RW-1:0]         ram_wdata;

	logic                  res_valid_q;
	logic [RW-1:0]         res_room_q;
	logic [RW-1:0]         res_occ_q;
	logic [RW-1:0]         res_peak_q;
	logic                  res_full_q;

	// bits of the last word past the last room count as busy
	always_comb begin
		busy_pad                = '1;
		busy_pad[MAX_ROOMS-1:0] = busy_q;
		for (int w = 0; w < NWORDS; w++) begin
			words[w]     = busy_pad[w*BMP_WORD_W +: BMP_WORD_W];
			word_full[w] = &words[w];
		end
	end

	// first word with a free room
	always_comb begin
		free_word = '0;
		free_any  = 1'b0;
		for (int w = NWORDS - 1; w >= 0; w--) begin
			if (!word_full[w]) begin
				free_word = NWW'(w);
				free_any  = 1'b1;
			end
		end
	end

	// lowest free room inside the chosen word
	always_comb begin
		word_cur = words[word_sel_q];
		low_bit  = '0;
		for (int b = BMP_WORD_W - 1; b >= 0; b--) begin
			if (!word_cur[b]) begin
				low_bit = BMP_BIT_W'(b);
			end
		end
		alloc_idx  = RIW'({word_sel_q, low_bit});
		alloc_room = RW'({word_sel_q, low_bit}) + RW'(1);
	end

	assign out_free = !res_valid_q || res.ready;

	always_comb begin : next_state
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin : fsm_out
		pop_ready = 1'b0;
		take      = 1'b0;
		commit    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				take      = pop_valid;
			end
			BK_EXEC: begin
				commit = out_free;
			end
			default: ;
		endcase
	end

	// departure check against the table entry read when the command was taken
	always_comb begin
		held_idx = RIW'(held - RW'(1));
		held_ok  = (held != '0) && (held <= RW'(MAX_ROOMS)) && busy_q[held_idx];
	end

	always_comb begin
		arrive   = cmd_q.kind == REQ_ARRIVE;
		do_alloc = commit && cmd_q.guest_ok && arrive && word_any_q;
		do_free  = commit && cmd_q.guest_ok && !arrive && held_ok;
		occ_inc  = occ_q + RW'(1);
		occ_d    = occ_q;
		peak_d   = peak_q;
		room_d   = '0;
		if (do_alloc) begin
			occ_d  = occ_inc;
			room_d = alloc_room;
			if (occ_inc > peak_q) begin
				peak_d = occ_inc;
			end
		end else if (do_free) begin
			room_d = held;
			if (occ_q != '0) begin
				occ_d = occ_q - RW'(1);
			end
		end
		full_d    = cmd_q.guest_ok && arrive && !word_any_q;
		ram_we    = commit && cmd_q.guest_ok;
		ram_wdata = (arrive && word_any_q) ? alloc_room : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			busy_q      <= '0;
			occ_q       <= '0;
			peak_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			peak_q  <= peak_d;
			if (do_alloc) begin
				busy_q[alloc_idx] <= 1'b1;
			end
			if (do_free) begin
				busy_q[held_idx] <= 1'b0;
			end
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q      <= pop_data;
			word_sel_q <= free_word;
			word_any_q <= free_any;
		end
		if (commit) begin
			res_room_q <= room_d;
			res_occ_q  <= occ_d;
			res_peak_q <= peak_d;
			res_full_q <= full_d;
		end
	end

	lfra_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_GUESTS)
	) u_guest_tbl (
		.clk  (clk),
		.we   (ram_we),
		.waddr(GW'(cmd_q.guest)),
		.wdata(ram_wdata),
		.re   (take),
		.raddr(GW'(pop_data.guest)),
		.rdata(held)
	);

	assign res.valid    = res_valid_q;
	assign res.room     = ROOM_FIELD_W'(res_room_q);
	assign res.occupied = ROOM_FIELD_W'(res_occ_q);
	assign res.peak     = ROOM_FIELD_W'(res_peak_q);
	assign res.full_res = res_full_q;
endmodule

FILE: rtl/lfra_checker.sv
// Port-level checks of the room allocator and their binding to the top level.
module lfra_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [8:0] room,
	input logic [8:0] occupied,
	input logic [8:0] peak,
	input logic       full_res
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(room) && $stable(occupied)
			&& $stable(peak) && $stable(full_res))
		else $error("result beat changed while stalled");

	a_full_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && full_res |-> room == 9'd0 && occupied == peak)
		else $error("full result with a room or with occupancy below peak");

	a_room_peak: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && room != 9'd0 |-> peak != 9'd0)
		else $error("room reported while peak is zero");
endmodule

bind lowest_free_room_allocator_unit lfra_checker u_lfra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.room     (res.room),
	.occupied (res.occupied),
	.peak     (res.peak),
	.full_res (res.full_res)
);
